// ----- sv/swsl_pkg.sv -----
`default_nettype none

package swsl_pkg;

  // window depth and fraction bits of the slope threshold
  localparam int WINDOW    = 64;
  localparam int FRAC_BITS = 8;

  localparam int SampleW = 32;
  localparam int SlopeW  = 16;
  localparam int LisW    = 7;
  localparam int LisMax  = 127;

  // window position and count widths
  localparam int PosW = $clog2(WINDOW);
  localparam int CntW = $clog2(WINDOW + 1);

  // slope test widths
  localparam int DvW   = SampleW + 1;
  localparam int DtW   = PosW + 1;
  localparam int ProdW = SlopeW + DtW;
  localparam int LhsW  = DvW + FRAC_BITS;
  localparam int CmpW  = ((LhsW > ProdW) ? LhsW : ProdW) + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ELEM_RD,
    ST_SCAN,
    ST_DRAIN,
    ST_WRITE,
    ST_RESULT
  } ctl_state_t;

  typedef struct packed {
    logic push;
    logic elem_rd;
    logic scan_issue;
    logic write;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic len_zero;
    logic scan_last;
    logic pipe_empty;
    logic elem_last;
  } dp_stat_t;

  typedef struct packed {
    logic [SampleW-1:0] value;
    logic [PosW-1:0]    pos;
  } tail_entry_t;

endpackage

`default_nettype wire

// ----- sv/swsl_ctrl.sv -----
`default_nettype none

module swsl_ctrl
  import swsl_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  output ctl_cmd_t      cmd,
  input  wire dp_stat_t stat
);

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_ELEM_RD;
      end
      ST_ELEM_RD: begin
        state_nxt = stat.len_zero ? ST_WRITE : ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (stat.pipe_empty) state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        state_nxt = stat.elem_last ? ST_RESULT : ST_ELEM_RD;
      end
      ST_RESULT: begin
        if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd           = '0;
    in_stall      = 1'b1;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.push = in_valid;
      end
      ST_ELEM_RD: cmd.elem_rd    = 1'b1;
      ST_SCAN:    cmd.scan_issue = 1'b1;
      ST_DRAIN:   cmd            = '0;
      ST_WRITE:   cmd.write      = 1'b1;
      ST_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_result_from_result_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RESULT))
    else $error("result appeared outside the result state");

  a_write_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE) |-> stat.pipe_empty)
    else $error("tail write while the scan pipeline is busy");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r)
    else $error("stalled result dropped");
`endif

endmodule

`default_nettype wire

// ----- sv/swsl_dp.sv -----
`default_nettype none

module swsl_dp
  import swsl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [SampleW-1:0] in_sample,
  input  wire logic               cfg_we,
  input  wire logic [SlopeW-1:0]  cfg_slope_threshold,
  input  wire ctl_cmd_t           cmd,
  output dp_stat_t                stat,
  output logic [LisW-1:0]         out_lis_length
);

  logic [SampleW-1:0] window_mem [WINDOW];
  tail_entry_t        tail_mem   [WINDOW];

  logic signed [SlopeW-1:0] slope_r;
  logic [PosW-1:0]  oldest_r, next_r;
  logic [CntW-1:0]  fill_r, fill_nxt;
  logic [CntW-1:0]  len_r, rank_r;
  logic [PosW-1:0]  i_r, k_r;
  logic [SampleW-1:0] win_q_r;
  tail_entry_t      tail_q_r;
  logic             s1_v_r, s2_v_r;
  logic [PosW-1:0]  s1_k_r, s2_k_r;
  logic signed [DvW-1:0]   dv_r;
  logic signed [ProdW-1:0] prod_r;
  logic [LisW-1:0]  out_len_r;

  logic [PosW:0]    win_sum;
  logic [PosW-1:0]  win_addr;
  logic signed [DvW-1:0]   dv_nxt;
  logic signed [DtW-1:0]   dt;
  logic signed [ProdW-1:0] prod_nxt;
  logic signed [CmpW-1:0]  lhs, rhs;
  logic             passes;
  logic [CntW-1:0]  sat_len;

  // window slot of element i, oldest first
  assign win_sum  = {1'b0, oldest_r} + {1'b0, i_r};
  assign win_addr = (win_sum >= (PosW+1)'(WINDOW)) ? PosW'(win_sum - (PosW+1)'(WINDOW))
                                                    : win_sum[PosW-1:0];

  assign fill_nxt = (fill_r == CntW'(WINDOW)) ? fill_r : fill_r + CntW'(1);

  // stage 2 operands
  assign dv_nxt   = $signed({win_q_r[SampleW-1], win_q_r})
                  - $signed({tail_q_r.value[SampleW-1], tail_q_r.value});
  assign dt       = $signed({1'b0, i_r}) - $signed({1'b0, tail_q_r.pos});
  assign prod_nxt = slope_r * dt;

  // stage 3 compare
  assign lhs    = CmpW'(dv_r) <<< FRAC_BITS;
  assign rhs    = CmpW'(prod_r);
  assign passes = (lhs >= rhs);

  assign sat_len = len_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slope_r  <= '0;
      oldest_r <= '0;
      next_r   <= '0;
      fill_r   <= '0;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      len_r    <= '0;
      rank_r   <= '0;
      i_r      <= '0;
      k_r      <= '0;
    end else begin
      if (cfg_we) slope_r <= $signed(cfg_slope_threshold);
      s1_v_r <= cmd.scan_issue;
      s2_v_r <= s1_v_r;
      if (cmd.push) begin
        if (fill_r == CntW'(WINDOW)) begin
          oldest_r <= (oldest_r == PosW'(WINDOW - 1)) ? '0 : oldest_r + PosW'(1);
        end
        next_r <= (next_r == PosW'(WINDOW - 1)) ? '0 : next_r + PosW'(1);
        fill_r <= fill_nxt;
        len_r  <= '0;
        i_r    <= '0;
      end
      if (cmd.elem_rd) begin
        k_r    <= '0;
        rank_r <= '0;
      end else if (s2_v_r && passes) begin
        rank_r <= CntW'(s2_k_r) + CntW'(1);
      end
      if (cmd.scan_issue) k_r <= k_r + PosW'(1);
      if (cmd.write) begin
        if (rank_r == len_r) len_r <= len_r + CntW'(1);
        if (!stat.elem_last) i_r <= i_r + PosW'(1);
      end
    end
  end

  // window and tail memories
  always_ff @(posedge clk) begin
    if (cmd.push) window_mem[next_r] <= in_sample;
    if (cmd.elem_rd) win_q_r <= window_mem[win_addr];
    if (cmd.write) tail_mem[rank_r[PosW-1:0]] <= '{value: win_q_r, pos: i_r};
    if (cmd.scan_issue) tail_q_r <= tail_mem[k_r];
  end

  // scan pipeline payload
  always_ff @(posedge clk) begin
    s1_k_r <= k_r;
    s2_k_r <= s1_k_r;
    dv_r   <= dv_nxt;
    prod_r <= prod_nxt;
    if (cmd.load_out) begin
      out_len_r <= (32'(sat_len) > 32'(LisMax)) ? LisW'(LisMax) : LisW'(sat_len);
    end
  end

  always_comb begin
    stat.len_zero   = (len_r == '0);
    stat.scan_last  = ((CntW'(k_r) + CntW'(1)) == len_r);
    stat.pipe_empty = !s1_v_r && !s2_v_r;
    stat.elem_last  = ((CntW'(i_r) + CntW'(1)) == fill_r);
  end

  assign out_lis_length = out_len_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CntW'(WINDOW))
    else $error("fill count above window depth");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= fill_r)
    else $error("tail table longer than the window");

  a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write |-> (rank_r <= len_r) && (CntW'(i_r) < fill_r))
    else $error("tail write rank beyond table length");
`endif

endmodule

`default_nettype wire

// ----- sv/sliding_window_slope_lis_length_core.sv -----
`default_nettype none

// Sliding-window slope-constrained longest increasing subsequence length.
// Every in_sample transfer pushes one signed 32-bit value into a window of the
// last WINDOW samples (oldest one drops out once full), then rebuilds the tail
// table from the oldest window element to the newest and returns one
// out_lis_length. An element at window position t with value v extends the
// last tail p (in rank order) that meets
// (v - v_p) * 2^FRAC_BITS >= cfg_slope_threshold * (t - t_p), threshold in
// signed Q8.8. The processing time is set by the single tail memory read port,
// which feeds one slope comparison per cycle through a three-stage read,
// multiply and compare pipeline. Items are processed one at a time: in_stall
// is low only while the block is idle, and the result sits in an output
// register so the next sample can be taken while the previous result waits on
// out_stall. cfg_slope_threshold is written with cfg_we and should only change
// while the block is idle. No clearing pass is needed after reset.
module sliding_window_slope_lis_length_core
  import swsl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // sample channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [SampleW-1:0] in_sample,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [LisW-1:0]         out_lis_length,
  // threshold register write
  input  wire logic               cfg_we,
  input  wire logic [SlopeW-1:0]  cfg_slope_threshold
);

  // commands from the sequencer, status back from the datapath
  ctl_cmd_t cmd;
  dp_stat_t stat;

  // sequencer: accept, per-element read, scan, drain, tail write, result
  swsl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // window store, tail table, slope test pipeline, result register
  swsl_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_sample           (in_sample),
    .cfg_we              (cfg_we),
    .cfg_slope_threshold (cfg_slope_threshold),
    .cmd                 (cmd),
    .stat                (stat),
    .out_lis_length      (out_lis_length)
  );

endmodule

`default_nettype wire

// ----- sim/lis_length_checker.sv -----
`default_nettype none

module lis_length_checker
  import swsl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [SampleW-1:0] in_sample,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic [LisW-1:0]    out_lis_length,
  input  wire logic               cfg_we,
  input  wire logic [SlopeW-1:0]  cfg_slope_threshold,
  output int                      fail_count,
  output int                      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow of the sample window and the threshold register
  logic signed [SampleW-1:0] window_q [WINDOW];
  logic [PosW-1:0]           head_slot;
  logic [PosW-1:0]           write_slot;
  logic [CntW-1:0]           held;
  logic signed [SlopeW-1:0]  slope_q;

  logic [LisW-1:0] expected_lengths [$];
  logic [LisW-1:0] want;
  int              mismatches = 0;

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("lis_length_checker: %0t ns: %s", $time, what);
  endtask

  // rebuild the tail table over the held window, oldest first
  function automatic logic [LisW-1:0] lis_of_window();
    logic signed [SampleW-1:0] tail_val [WINDOW];
    int                        tail_pos [WINDOW];
    logic signed [SampleW-1:0] v;
    longint                    lhs;
    longint                    rhs;
    int                        len;
    int                        rank;
    len = 0;
    for (int i = 0; i < int'(held); i++) begin
      v = window_q[(int'(head_slot) + i) % WINDOW];
      rank = 0;
      for (int k = 0; k < len; k++) begin
        lhs = (longint'(v) - longint'(tail_val[k])) * (longint'(1) << FRAC_BITS);
        rhs = longint'(slope_q) * longint'(i - tail_pos[k]);
        if (lhs >= rhs) rank = k + 1;
      end
      if (rank < WINDOW) begin
        tail_val[rank] = v;
        tail_pos[rank] = i;
      end
      if (rank == len) len++;
    end
    if (len > LisMax) len = LisMax;
    return LisW'(len);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      head_slot  = '0;
      write_slot = '0;
      held       = '0;
      slope_q    = '0;
      expected_lengths.delete();
    end else begin
      if (cfg_we) slope_q = cfg_slope_threshold;

      if (out_valid && !out_stall) begin
        if (expected_lengths.size() == 0) begin
          report_mismatch($sformatf("lis_length %0d with no sample outstanding",
                                    out_lis_length));
        end else begin
          want = expected_lengths.pop_front();
          if (out_lis_length !== want)
            report_mismatch($sformatf("lis_length %0d, expected %0d", out_lis_length, want));
        end
      end

      if (in_valid && !in_stall) begin
        if (held >= WINDOW) head_slot = head_slot + 1'b1;
        window_q[write_slot] = in_sample;
        write_slot = write_slot + 1'b1;
        if (held < WINDOW) held = held + 1'b1;
        expected_lengths.push_back(lis_of_window());
      end
    end
    pending    <= expected_lengths.size();
    fail_count <= mismatches;
  end

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
`default_nettype none

module tb_top
  import swsl_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // generous bound: every item at full window cost plus the longest sender gap
  // and the longest receiver stall, taken almost four times over
  localparam int CycleLimit = 8_000_000;
  localparam int PhaseItems = 32;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [SampleW-1:0] in_sample = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [LisW-1:0]    out_lis_length;
  logic               cfg_we = 1'b0;
  logic [SlopeW-1:0]  cfg_slope_threshold = '0;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int stall_burst = 0;
  bit calm = 1'b0;     // set during the stretch with no idling on either side

  always #5 clk = ~clk;

  sliding_window_slope_lis_length_core u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sample           (in_sample),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_lis_length      (out_lis_length),
    .cfg_we              (cfg_we),
    .cfg_slope_threshold (cfg_slope_threshold)
  );

  lis_length_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sample           (in_sample),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_lis_length      (out_lis_length),
    .cfg_we              (cfg_we),
    .cfg_slope_threshold (cfg_slope_threshold),
    .fail_count          (fail_count),
    .pending             (pending)
  );

  // result side back-pressure: mostly short random stalls, rarely a long
  // burst so a finished result has to wait in the output register
  always @(negedge clk) begin
    if (calm) begin
      out_stall <= 1'b0;
    end else if (stall_burst != 0) begin
      stall_burst <= stall_burst - 1;
      out_stall   <= 1'b1;
    end else if ($urandom_range(0, 19999) == 0) begin
      stall_burst <= $urandom_range(200, 2500);
      out_stall   <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 25);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // one sample transfer; an optional idle gap goes in front of it, mostly
  // short, sometimes long enough that the block has gone idle meanwhile
  task automatic send_sample(input logic [SampleW-1:0] value);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < 25)
      gap = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(200, 2600);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= value;
    do begin
      @(posedge clk);
    end while (in_stall);
  endtask

  // drop valid and wait until every outstanding result has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  // threshold writes only happen with the block idle
  task automatic write_slope(input logic [SlopeW-1:0] thr);
    wait_drained();
    @(negedge clk);
    cfg_we              <= 1'b1;
    cfg_slope_threshold <= thr;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    logic [SlopeW-1:0]  slopes [8];
    logic [SampleW-1:0] specials [6];
    int                 mode;
    int                 run_left;
    int                 ramp_step;
    int                 ramp_val;
    logic [SampleW-1:0] v;

    slopes   = '{16'h0000, 16'h0100, 16'hFF00, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h0040};
    slopes[5] = SlopeW'($urandom());
    slopes[6] = SlopeW'($urandom());
    specials = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                 32'h7FFF_FFFE, 32'h8000_0001};

    // synchronous reset
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // flat threshold: rising run, equal neighbors, full-scale jumps
    write_slope(16'h0000);
    send_sample(32'd0);          send_sample(32'd1);          send_sample(32'd2);
    send_sample(32'd2);          send_sample(32'hFFFF_FFFF);  send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);  send_sample(32'hFFFF_FFFF);  send_sample(32'd0);

    // steepest positive slope: widest value difference against the largest threshold
    write_slope(16'h7FFF);
    send_sample(32'h8000_0000);  send_sample(32'h7FFF_FFFF);  send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);  send_sample(32'd5);          send_sample(32'd6);

    // most negative slope: falling values may still chain
    write_slope(16'h8000);
    send_sample(32'h7FFF_FFFF);  send_sample(32'd0);          send_sample(32'h8000_0000);
    send_sample(32'd100);        send_sample(32'd99);         send_sample(32'hFFFF_FFFB);

    // slope of exactly one per position, hitting the boundary with equality
    write_slope(16'h0100);
    send_sample(32'd10);         send_sample(32'd11);         send_sample(32'd13);
    send_sample(32'd13);

    // random phases, one threshold each; content comes in runs, mostly ramps
    // whose step sits near the threshold so the slope test goes both ways
    for (int p = 0; p < 8; p++) begin
      write_slope(slopes[p]);
      calm     = (p == 3);
      ramp_val = int'($urandom());
      run_left = 0;
      for (int n = 0; n < PhaseItems; n++) begin
        if (run_left == 0) begin
          run_left  = $urandom_range(8, 24);
          mode      = $urandom_range(0, 99);
          ramp_step = (int'($signed(slopes[p])) >>> FRAC_BITS) + int'($urandom_range(0, 6)) - 3;
          if ($urandom_range(0, 1) == 1) ramp_val = int'($urandom());
        end
        run_left--;
        if (mode < 50) begin
          ramp_val = ramp_val + ramp_step + int'($urandom_range(0, 4)) - 2;
          v = SampleW'(ramp_val);
        end else if (mode < 70) begin
          v = SampleW'(int'($urandom_range(0, 15)) - 8);
        end else if (mode < 85) begin
          v = $urandom();
        end else begin
          v = specials[$urandom_range(0, 5)];
        end
        send_sample(v);
      end
    end
    calm = 1'b0;

    // let the last results come back, then a short tail
    wait_drained();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
